### sv/tcce_pkg.sv
`default_nettype none

package tcce_pkg;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_FIRST,
		ST_OOB,
		ST_SCROLL,
		ST_SCR_CLR,
		ST_SCR_RES,
		ST_RDREQ,
		ST_REDRAW,
		ST_MOVED
	} state_t;

	typedef enum logic [1:0] {
		KIND_DRAW   = 2'd0,
		KIND_MOVED  = 2'd1,
		KIND_SCROLL = 2'd2,
		KIND_OOB    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  glyph;
		logic [6:0]  col;
		logic [5:0]  row;
		logic        last;
	} res_t;

	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_COLUMNS = 2'd1;
	localparam logic [1:0] REG_ROWS    = 2'd2;

	localparam logic [1:0] MODE_WRAP    = 2'd1;
	localparam logic [1:0] MODE_NEWLINE = 2'd2;

	localparam logic [1:0] MODE_RST    = MODE_NEWLINE;
	localparam logic [7:0] COLUMNS_RST = 8'd80;
	localparam logic [6:0] ROWS_RST    = 7'd25;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'd32;
	localparam logic [7:0] CH_NUL       = 8'd0;

	function automatic logic [7:0] shown(input logic [7:0] b);
		return (b == CH_NEWLINE) ? CH_SPACE : b;
	endfunction

endpackage

`default_nettype wire

### sv/tcce_ram.sv
`default_nettype none

module tcce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/tcce_obuf.sv
`default_nettype none

module tcce_obuf import tcce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  res_t       din,
	output logic       free,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] kind,
	output logic [7:0] glyph,
	output logic [6:0] col,
	output logic [5:0] row,
	output logic       last
);

	logic valid_q;
	res_t data_q;

	assign free = !valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= din;
		end
	end

	assign res_valid = valid_q;
	assign kind      = data_q.kind;
	assign glyph     = data_q.glyph;
	assign col       = data_q.col;
	assign row       = data_q.row;
	assign last      = data_q.last;

endmodule

`default_nettype wire

### sv/text_console_cursor_engine.sv
`default_nettype none

// channel   signals                                  direction
// char      char_valid, char_stall, char_in          request in, one character
// result    res_valid, res_stall, kind, glyph,       request out, up to four
//           col, row, last                           per character
// config    cfg_valid, cfg_ready, cfg_index,         register write in
//           cfg_data
//
// printable or backspace: accept, decide, first draw, store read, redraw, move; newline:
// the same, no first draw; backspace at column zero: taken, no result; out of bounds stop:
// at most a first draw and a stop result; a scroll adds (rows-1)*columns store copies at
// one per cycle, a drain if rows > 1, columns clears and the scroll result, all on the
// single store port pair; after reset all MAX_COLS*MAX_ROWS store cells (8192 at the
// defaults) are cleared before char_stall drops; config writes are taken meanwhile
// res_stall holds the result register and the sequencer waits on it

module text_console_cursor_engine import tcce_pkg::*; #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_in,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] kind,
	output logic [7:0] glyph,
	output logic [6:0] col,
	output logic [5:0] row,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);

	function automatic logic [AW-1:0] cell_addr(input logic [8:0] c, input logic [7:0] r);
		return AW'(32'(r) * 32'(MAX_COLS) + 32'(c));
	endfunction

	state_t         state_q, state_d;
	logic [AW-1:0]  clr_q;
	logic [1:0]     mode_q;
	logic [7:0]     columns_q;
	logic [6:0]     rows_q;
	logic [6:0]     cur_col_q;
	logic [5:0]     cur_row_q;
	logic [CW-1:0]  sx_q;
	logic [RW-1:0]  sy_q;
	logic           cp_s1;
	logic [AW-1:0]  cp_addr_s1;
	logic [7:0]     ch_q;
	logic           move_ok_q;
	logic           scroll_q;
	logic [6:0]     nx_q;
	logic [5:0]     ny_q;

	logic [8:0]     nc;
	logic [7:0]     nr;
	logic [CW-1:0]  nc_m1;
	logic [RW-1:0]  nr_m1;
	logic           is_nl, is_bs;
	logic [8:0]     tx;
	logic [7:0]     ty;
	logic           ovf;
	logic           dec_ok, dec_scroll;
	logic [8:0]     dec_x;
	logic [7:0]     dec_y;
	state_t         scroll_entry;

	logic           we, re;
	logic [AW-1:0]  waddr, raddr;
	logic [7:0]     wdata, rd_data;
	logic           push, obuf_free;
	res_t           res;

	assign cfg_ready = 1'b1;

	// saturated area in use
	always_comb begin
		if (columns_q == 8'd0) begin
			nc = 9'd1;
		end else if (9'(columns_q) > 9'(MAX_COLS)) begin
			nc = 9'(MAX_COLS);
		end else begin
			nc = 9'(columns_q);
		end
		if (rows_q == 7'd0) begin
			nr = 8'd1;
		end else if (8'(rows_q) > 8'(MAX_ROWS)) begin
			nr = 8'(MAX_ROWS);
		end else begin
			nr = 8'(rows_q);
		end
	end

	assign nc_m1        = CW'(nc - 9'd1);
	assign nr_m1        = RW'(nr - 8'd1);
	assign scroll_entry = (nr == 8'd1) ? ST_SCR_CLR : ST_SCROLL;

	// cursor move decision
	assign is_nl = (ch_q == CH_NEWLINE);
	assign is_bs = (ch_q == CH_BACKSPACE);
	assign tx    = is_nl ? 9'd0 : (is_bs ? 9'(cur_col_q) - 9'd1 : 9'(cur_col_q) + 9'd1);
	assign ty    = is_nl ? 8'(cur_row_q) + 8'd1 : 8'(cur_row_q);
	assign ovf   = (tx >= nc) || (ty >= nr);

	always_comb begin
		dec_ok     = 1'b1;
		dec_scroll = 1'b0;
		dec_x      = tx;
		dec_y      = ty;
		if (ovf) begin
			case (mode_q)
				MODE_WRAP: begin
					dec_x = 9'd0;
					if (ty >= nr) begin
						dec_y = 8'd0;
					end
				end
				MODE_NEWLINE: begin
					dec_x = 9'd0;
					if (9'(ty) + 9'd1 >= 9'(nr)) begin
						dec_scroll = 1'b1;
						dec_y      = nr - 8'd1;
					end else begin
						dec_y = ty + 8'd1;
					end
				end
				default: begin
					dec_ok = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		char_stall = 1'b1;
		we         = 1'b0;
		waddr      = '0;
		wdata      = CH_NUL;
		re         = 1'b0;
		raddr      = '0;
		push       = 1'b0;
		res        = '0;
		if (cp_s1) begin
			we    = 1'b1;
			waddr = cp_addr_s1;
			wdata = rd_data;
		end
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = CH_NUL;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				char_stall = 1'b0;
				if (char_valid) begin
					if (char_in == CH_BACKSPACE) begin
						if (cur_col_q != 7'd0) begin
							we      = 1'b1;
							waddr   = cell_addr(9'(cur_col_q) - 9'd1, 8'(cur_row_q));
							wdata   = CH_SPACE;
							state_d = ST_DECIDE;
						end
					end else begin
						we      = 1'b1;
						waddr   = cell_addr(9'(cur_col_q), 8'(cur_row_q));
						wdata   = char_in;
						state_d = ST_DECIDE;
					end
				end
			end
			ST_DECIDE: begin
				if (!is_nl) begin
					state_d = ST_FIRST;
				end else if (!dec_ok) begin
					state_d = ST_IDLE;
				end else if (dec_scroll) begin
					state_d = scroll_entry;
				end else begin
					state_d = ST_RDREQ;
				end
			end
			ST_FIRST: begin
				push      = obuf_free;
				res.kind  = KIND_DRAW;
				res.glyph = is_bs ? CH_SPACE : ch_q;
				res.col   = is_bs ? cur_col_q - 7'd1 : cur_col_q;
				res.row   = cur_row_q;
				res.last  = !move_ok_q && is_bs;
				if (obuf_free) begin
					if (!move_ok_q) begin
						state_d = is_bs ? ST_IDLE : ST_OOB;
					end else if (scroll_q) begin
						state_d = scroll_entry;
					end else begin
						state_d = ST_RDREQ;
					end
				end
			end
			ST_OOB: begin
				push     = obuf_free;
				res.kind = KIND_OOB;
				res.col  = cur_col_q;
				res.row  = cur_row_q;
				res.last = 1'b1;
				if (obuf_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCROLL: begin
				re    = 1'b1;
				raddr = cell_addr(9'(sx_q), 8'(sy_q));
				if (sx_q == nc_m1 && sy_q == nr_m1) begin
					state_d = ST_SCR_CLR;
				end
			end
			ST_SCR_CLR: begin
				if (!cp_s1) begin
					we    = 1'b1;
					waddr = cell_addr(9'(sx_q), 8'(nr_m1));
					wdata = CH_NUL;
					if (sx_q == nc_m1) begin
						state_d = ST_SCR_RES;
					end
				end
			end
			ST_SCR_RES: begin
				push     = obuf_free;
				res.kind = KIND_SCROLL;
				if (obuf_free) begin
					state_d = ST_RDREQ;
				end
			end
			ST_RDREQ: begin
				re      = 1'b1;
				raddr   = cell_addr(9'(cur_col_q), 8'(cur_row_q));
				state_d = ST_REDRAW;
			end
			ST_REDRAW: begin
				push      = obuf_free;
				res.kind  = KIND_DRAW;
				res.glyph = shown(rd_data);
				res.col   = cur_col_q;
				res.row   = cur_row_q;
				if (obuf_free) begin
					state_d = ST_MOVED;
				end
			end
			ST_MOVED: begin
				push     = obuf_free;
				res.kind = KIND_MOVED;
				res.col  = cur_col_q;
				res.row  = cur_row_q;
				res.last = 1'b1;
				if (obuf_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RST;
			columns_q <= COLUMNS_RST;
			rows_q    <= ROWS_RST;
			cur_col_q <= 7'd0;
			cur_row_q <= 6'd0;
			clr_q     <= '0;
			sx_q      <= '0;
			sy_q      <= '0;
			cp_s1     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:    mode_q    <= cfg_data[1:0];
					REG_COLUMNS: columns_q <= cfg_data;
					REG_ROWS:    rows_q    <= cfg_data[6:0];
					default:     ;
				endcase
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			cp_s1 <= (state_q == ST_SCROLL);
			if (state_q == ST_REDRAW && obuf_free) begin
				cur_col_q <= nx_q;
				cur_row_q <= ny_q;
			end
			case (state_q)
				ST_DECIDE, ST_FIRST: begin
					sx_q <= '0;
					sy_q <= RW'(1);
				end
				ST_SCROLL: begin
					if (sx_q == nc_m1) begin
						sx_q <= '0;
						sy_q <= sy_q + RW'(1);
					end else begin
						sx_q <= sx_q + CW'(1);
					end
				end
				ST_SCR_CLR: begin
					if (!cp_s1) begin
						sx_q <= sx_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && char_valid) begin
			ch_q <= char_in;
		end
		if (state_q == ST_DECIDE) begin
			move_ok_q <= dec_ok;
			scroll_q  <= dec_scroll;
			nx_q      <= dec_x[6:0];
			ny_q      <= dec_y[5:0];
		end
		if (state_q == ST_SCROLL) begin
			cp_addr_s1 <= cell_addr(9'(sx_q), 8'(sy_q - RW'(1)));
		end
	end

	tcce_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_data)
	);

	tcce_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (res),
		.free      (obuf_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.kind      (kind),
		.glyph     (glyph),
		.col       (col),
		.row       (row),
		.last      (last)
	);

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_CLEAR |=> state_q != ST_CLEAR)
		else $error("store clear pass entered again");

	a_copy_from_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		cp_s1 |-> $past(state_q) == ST_SCROLL)
		else $error("scroll copy write without a scroll read");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> obuf_free)
		else $error("result pushed into a full output register");

	a_cursor_update: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_col_q != $past(cur_col_q) || cur_row_q != $past(cur_row_q))
		|-> $past(state_q) == ST_REDRAW)
		else $error("cursor changed outside the redraw step");

endmodule

`default_nettype wire
